// ===== design/itoa_pkg.sv =====
package itoa_pkg;

  // input word and digit geometry
  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned DigitIdxW = $clog2(NumDigits);
  localparam int unsigned StepCntW  = $clog2(ValueW);
  localparam int unsigned CharW     = 8;

  // ascii codes
  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // one converted number handed from front to back
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
  } conv_t;

endpackage

// ===== design/itoa_front.sv =====
module itoa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [itoa_pkg::ValueW-1:0]      in_value_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output itoa_pkg::conv_t                  push_data_o
);

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_CONV = 3'b010,
    FE_PUSH = 3'b100
  } fe_state_e;

  fe_state_e                          state_q, state_d;
  logic [itoa_pkg::StepCntW-1:0]      cnt_q, cnt_d;
  logic [itoa_pkg::ValueW-1:0]        bin_q, bin_d;
  logic [itoa_pkg::BcdW-1:0]          bcd_q, bcd_d;
  logic                               neg_q, neg_d;
  logic [itoa_pkg::BcdW-1:0]          bcd_adj;
  logic                               in_fire;

  assign in_ready_o   = (state_q == FE_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign push_valid_o = (state_q == FE_PUSH);
  assign push_data_o  = '{neg: neg_q, bcd: bcd_q};

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < itoa_pkg::NumDigits; d++) begin
      if (bcd_q[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
  end

  // sequencer: take a word, run one shift-add-3 step per cycle, hand off
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      FE_IDLE: begin
        if (in_fire) begin
          neg_d   = in_value_i[itoa_pkg::ValueW-1];
          bin_d   = in_value_i[itoa_pkg::ValueW-1] ? (~in_value_i + 1'b1) : in_value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FE_CONV;
        end
      end
      FE_CONV: begin
        bcd_d = {bcd_adj[itoa_pkg::BcdW-2:0], bin_q[itoa_pkg::ValueW-1]};
        bin_d = {bin_q[itoa_pkg::ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == itoa_pkg::StepCntW'(itoa_pkg::ValueW - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (push_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

// ===== design/itoa_queue.sv =====
module itoa_queue #(
  parameter int unsigned Depth = itoa_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  itoa_pkg::conv_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output itoa_pkg::conv_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  itoa_pkg::conv_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/itoa_back.sv =====
module itoa_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  itoa_pkg::conv_t              pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itoa_pkg::CharW-1:0]   out_char_o,
  output logic                         out_last_o
);

  logic                              busy_q;
  logic                              neg_pend_q;
  logic [itoa_pkg::DigitIdxW-1:0]    idx_q;
  logic [itoa_pkg::BcdW-1:0]         bcd_q;
  logic                              out_valid_q;
  logic [itoa_pkg::CharW-1:0]        out_char_q;
  logic                              out_last_q;
  logic [itoa_pkg::DigitIdxW-1:0]    top_idx;
  logic [3:0]                        digs [itoa_pkg::NumDigits];
  logic                              out_free;
  logic                              emit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = !busy_q;
  assign emit        = busy_q && out_free;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // digit view of the held bcd word
  always_comb begin
    for (int d = 0; d < itoa_pkg::NumDigits; d++) begin
      digs[d] = bcd_q[4*d +: 4];
    end
  end

  // highest nonzero digit of the incoming word, zero if all digits are zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < itoa_pkg::NumDigits; d++) begin
      if (pop_data_i.bcd[4*d +: 4] != 4'd0) begin
        top_idx = itoa_pkg::DigitIdxW'(d);
      end
    end
  end

  // character sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      neg_pend_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (!busy_q) begin
        if (pop_valid_i) begin
          busy_q     <= 1'b1;
          neg_pend_q <= pop_data_i.neg;
          idx_q      <= top_idx;
        end
      end else if (emit) begin
        if (neg_pend_q) begin
          neg_pend_q <= 1'b0;
        end else if (idx_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!busy_q && pop_valid_i) begin
      bcd_q <= pop_data_i.bcd;
    end
    if (emit) begin
      if (neg_pend_q) begin
        out_char_q <= itoa_pkg::CharMinus;
        out_last_q <= 1'b0;
      end else begin
        out_char_q <= itoa_pkg::CharZero + {4'd0, digs[idx_q]};
        out_last_q <= (idx_q == '0);
      end
    end
  end

endmodule

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// Converts each 32-bit two's complement word on the slave stream into its decimal
// text on the master stream, one ascii character per transfer, most significant
// first, with a leading '-' for negative values, no leading zeros, and tlast on
// the final digit; zero gives the single character '0'. The front end takes the
// word, runs the 32 shift-add-3 steps of the binary-to-bcd converter, hands off
// to the queue, and holds its input ready low meanwhile. The back end loads a
// number and then sends one character per cycle while the master stream accepts
// them, taking no new number while it is busy with one. A queue of QueueDepth
// numbers sits between the two.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned QueueDepth = itoa_pkg::QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [31:0] value
  input  logic [31:0]                s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] char_code
  output logic [7:0]                 m_axis_tdata_o,
  // is_last
  output logic                       m_axis_tlast_o
);

  logic            q_push_valid, q_push_ready;
  itoa_pkg::conv_t q_push_data;
  logic            q_pop_valid, q_pop_ready;
  itoa_pkg::conv_t q_pop_data;

  // word intake and binary to bcd conversion
  itoa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  // converted numbers waiting for the back end
  itoa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  // character emission
  itoa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_data_i   (q_pop_data),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // front never takes a new word while it still owes a handoff
  a_no_take_while_pushing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !q_push_valid
  ) else $error("front ready while a converted number is pending");

  // a blocked handoff stays offered
  a_push_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && !q_push_ready |=> q_push_valid
  ) else $error("front dropped a converted number");

  // the final character of a number is always a digit
  a_last_is_digit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      (m_axis_tdata_o >= itoa_pkg::CharZero) &&
      (m_axis_tdata_o <= itoa_pkg::CharZero + 8'd9)
  ) else $error("tlast on a non-digit character");

  // a minus sign is always followed by a digit of the same number
  a_minus_not_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == itoa_pkg::CharMinus) |-> !m_axis_tlast_o
  ) else $error("minus sign flagged as last character");

endmodule
